FILE: design/ccp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_pkg - constant-pool parser shared definitions
// Phases, tag and kind codes, operand formats and the front-to-back command.
// ----------------------------------------------------------------------------
package ccp_pkg;

	// Parser phases
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TAG,
		PH_OPERAND,
		PH_ULEN,
		PH_UBYTES,
		PH_IDLE
	} ccp_phase_t;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_STRING = 2'd2;

	// Constant-pool tags
	localparam logic [7:0] TAG_UTF8        = 8'd1;
	localparam logic [7:0] TAG_INTEGER     = 8'd3;
	localparam logic [7:0] TAG_FLOAT       = 8'd4;
	localparam logic [7:0] TAG_LONG        = 8'd5;
	localparam logic [7:0] TAG_DOUBLE      = 8'd6;
	localparam logic [7:0] TAG_CLASS       = 8'd7;
	localparam logic [7:0] TAG_STRING      = 8'd8;
	localparam logic [7:0] TAG_FIELDREF    = 8'd9;
	localparam logic [7:0] TAG_METHODREF   = 8'd10;
	localparam logic [7:0] TAG_IMETHODREF  = 8'd11;
	localparam logic [7:0] TAG_NAMEANDTYPE = 8'd12;

	// Byte counts
	localparam logic [3:0] HDR_MAGIC_END = 4'd4;
	localparam logic [3:0] HDR_VER_END   = 4'd8;
	localparam logic [3:0] HDR_LEN       = 4'd10;
	localparam logic [3:0] ULEN_BYTES    = 4'd2;
	localparam logic [3:0] OPND_SHORT    = 4'd2;
	localparam logic [3:0] OPND_WIDE     = 4'd8;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// How the back end maps the assembled value onto word_high / word_low
	typedef enum logic [2:0] {
		FMT_ZERO,   // both words zero
		FMT_SHORT,  // high = value[15:0]
		FMT_WORD,   // high = value[31:0]
		FMT_PAIR,   // high = value[31:16], low = value[15:0]
		FMT_WIDE    // high = value[63:32], low = value[31:0]
	} ccp_fmt_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] index;
		logic [7:0]  tag;
		ccp_fmt_t    fmt;
		logic [63:0] value;
		logic [7:0]  sbyte;
		logic        last;
	} ccp_cmd_t;

	function automatic logic [3:0] operand_bytes(input logic [7:0] t);
		logic [3:0] n;
		case (t)
			TAG_CLASS, TAG_STRING: n = OPND_SHORT;
			TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
			TAG_IMETHODREF, TAG_NAMEANDTYPE: n = 4'd4;
			TAG_LONG, TAG_DOUBLE: n = OPND_WIDE;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: design/ccp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_if - byte and result channels
// Valid/ready channels for the class-file byte stream and the parse results.
// ----------------------------------------------------------------------------
interface ccp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface ccp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] entry_index;
	logic [7:0]  tag;
	logic [31:0] word_high;
	logic [31:0] word_low;
	logic [7:0]  string_byte;
	logic        last;

	modport source (output valid, output kind, output entry_index, output tag,
		output word_high, output word_low, output string_byte, output last,
		input ready);
	modport sink   (input valid, input kind, input entry_index, input tag,
		input word_high, input word_low, input string_byte, input last,
		output ready);
endinterface
`default_nettype wire

FILE: design/ccp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_front - byte classifier and parse sequencer
// Walks header and pool entries one byte a beat and pushes result commands.
// ----------------------------------------------------------------------------
module ccp_front
	import ccp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	ccp_byte_if.sink    stream,
	input  wire logic   queue_full,
	output logic        push,
	output ccp_cmd_t    push_cmd
);

	ccp_phase_t  phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d, cnt_nx;
	logic [63:0] shift_q, shift_d, shift_nx;
	logic [31:0] magic_q, magic_d;
	logic [31:0] ver_q, ver_d;
	logic [15:0] pool_q, pool_d;
	logic [7:0]  tag_q, tag_d;
	logic [15:0] slot_q, slot_d;
	logic [15:0] rem_q, rem_d;
	logic        accept;
	logic        do_adv;
	logic        adv_two;
	logic [16:0] adv_sum;
	logic [3:0]  opnd_n;

	assign stream.ready = !queue_full;
	assign accept       = stream.valid && !queue_full;
	assign shift_nx     = {shift_q[55:0], stream.data_byte};
	assign cnt_nx       = cnt_q + 4'd1;
	assign opnd_n       = operand_bytes(tag_q);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		magic_d  = magic_q;
		ver_d    = ver_q;
		pool_d   = pool_q;
		tag_d    = tag_q;
		slot_d   = slot_q;
		rem_d    = rem_q;
		push     = 1'b0;
		push_cmd = '0;
		do_adv   = 1'b0;
		adv_two  = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					shift_d = shift_nx;
					cnt_d   = cnt_nx;
					if (cnt_nx == HDR_MAGIC_END) begin
						magic_d = shift_nx[31:0];
					end
					if (cnt_nx == HDR_VER_END) begin
						ver_d = shift_nx[31:0];
					end
					if (cnt_nx == HDR_LEN) begin
						pool_d         = shift_nx[15:0];
						push           = 1'b1;
						push_cmd.kind  = KIND_HEADER;
						push_cmd.index = shift_nx[15:0];
						push_cmd.fmt   = FMT_WIDE;
						push_cmd.value = {magic_q, ver_q};
						slot_d         = 16'd1;
						cnt_d          = '0;
						shift_d        = '0;
						phase_d        = (shift_nx[15:0] > 16'd1) ? PH_TAG : PH_IDLE;
					end
				end
				PH_TAG: begin
					tag_d   = stream.data_byte;
					cnt_d   = '0;
					shift_d = '0;
					if (stream.data_byte == TAG_UTF8) begin
						phase_d = PH_ULEN;
					end else if (operand_bytes(stream.data_byte) == 4'd0) begin
						// unknown tag: entry with zero words, one slot
						push           = 1'b1;
						push_cmd.kind  = KIND_ENTRY;
						push_cmd.index = slot_q;
						push_cmd.tag   = stream.data_byte;
						push_cmd.fmt   = FMT_ZERO;
						do_adv         = 1'b1;
					end else begin
						phase_d = PH_OPERAND;
					end
				end
				PH_OPERAND: begin
					shift_d = shift_nx;
					cnt_d   = cnt_nx;
					if (cnt_nx >= opnd_n) begin
						push           = 1'b1;
						push_cmd.kind  = KIND_ENTRY;
						push_cmd.index = slot_q;
						push_cmd.tag   = tag_q;
						push_cmd.value = shift_nx;
						if (opnd_n == OPND_SHORT) begin
							push_cmd.fmt = FMT_SHORT;
						end else if (opnd_n == OPND_WIDE) begin
							push_cmd.fmt = FMT_WIDE;
						end else if (tag_q == TAG_INTEGER || tag_q == TAG_FLOAT) begin
							push_cmd.fmt = FMT_WORD;
						end else begin
							push_cmd.fmt = FMT_PAIR;
						end
						do_adv  = 1'b1;
						adv_two = (tag_q == TAG_LONG) || (tag_q == TAG_DOUBLE);
					end
				end
				PH_ULEN: begin
					shift_d = shift_nx;
					cnt_d   = cnt_nx;
					if (cnt_nx >= ULEN_BYTES) begin
						rem_d          = shift_nx[15:0];
						push           = 1'b1;
						push_cmd.kind  = KIND_ENTRY;
						push_cmd.index = slot_q;
						push_cmd.tag   = tag_q;
						push_cmd.fmt   = FMT_SHORT;
						push_cmd.value = shift_nx;
						if (shift_nx[15:0] == 16'd0) begin
							do_adv = 1'b1;
						end else begin
							phase_d = PH_UBYTES;
							cnt_d   = '0;
							shift_d = '0;
						end
					end
				end
				PH_UBYTES: begin
					rem_d          = rem_q - 16'd1;
					push           = 1'b1;
					push_cmd.kind  = KIND_STRING;
					push_cmd.index = slot_q;
					push_cmd.tag   = tag_q;
					push_cmd.fmt   = FMT_ZERO;
					push_cmd.sbyte = stream.data_byte;
					push_cmd.last  = (rem_q == 16'd1);
					do_adv         = (rem_q == 16'd1);
				end
				default: begin
				end
			endcase
		end
		// step to the next slot, or idle once the pool is done
		adv_sum = {1'b0, slot_q} + {15'd0, adv_two, !adv_two};
		if (do_adv) begin
			slot_d  = adv_sum[15:0];
			phase_d = (adv_sum >= {1'b0, pool_q}) ? PH_IDLE : PH_TAG;
			cnt_d   = '0;
			shift_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			shift_q <= '0;
			magic_q <= '0;
			ver_q   <= '0;
			pool_q  <= '0;
			tag_q   <= '0;
			slot_q  <= 16'd1;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			magic_q <= magic_d;
			ver_q   <= ver_d;
			pool_q  <= pool_d;
			tag_q   <= tag_d;
			slot_q  <= slot_d;
			rem_q   <= rem_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/ccp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_queue - command queue
// Short FIFO that decouples the parse sequencer from the result stage.
// ----------------------------------------------------------------------------
module ccp_queue
	import ccp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire ccp_cmd_t  push_cmd,
	input  wire logic      pop,
	output logic           full,
	output logic           empty,
	output ccp_cmd_t       head
);

	ccp_cmd_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/ccp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_back - result formatter and output register
// Maps queued commands onto the result words and holds them for the sink.
// ----------------------------------------------------------------------------
module ccp_back
	import ccp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ccp_cmd_t  head,
	input  wire logic      empty,
	output logic           pop,
	ccp_result_if.source   result
);

	logic        valid_q;
	logic        load;
	logic [31:0] hi_c, lo_c;
	logic [1:0]  kind_q;
	logic [15:0] index_q;
	logic [7:0]  tag_q;
	logic [31:0] hi_q, lo_q;
	logic [7:0]  sbyte_q;
	logic        last_q;

	assign load = !valid_q || result.ready;
	assign pop  = load && !empty;

	always_comb begin
		hi_c = '0;
		lo_c = '0;
		case (head.fmt)
			FMT_SHORT: hi_c = {16'd0, head.value[15:0]};
			FMT_WORD:  hi_c = head.value[31:0];
			FMT_PAIR: begin
				hi_c = {16'd0, head.value[31:16]};
				lo_c = {16'd0, head.value[15:0]};
			end
			FMT_WIDE: begin
				hi_c = head.value[63:32];
				lo_c = head.value[31:0];
			end
			default: begin
				hi_c = '0;
				lo_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.kind;
			index_q <= head.index;
			tag_q   <= head.tag;
			hi_q    <= hi_c;
			lo_q    <= lo_c;
			sbyte_q <= head.sbyte;
			last_q  <= head.last;
		end
	end

	assign result.valid       = valid_q;
	assign result.kind        = kind_q;
	assign result.entry_index = index_q;
	assign result.tag         = tag_q;
	assign result.word_high   = hi_q;
	assign result.word_low    = lo_q;
	assign result.string_byte = sbyte_q;
	assign result.last        = last_q;

endmodule
`default_nettype wire

FILE: design/class_file_constant_pool_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// class_file_constant_pool_parser_core - class-file header and pool parser
// Parses the big-endian header and constant-pool entries of a class file.
// ----------------------------------------------------------------------------
//  channel | role   | beat carries
//  --------+--------+-----------------------------------------------------------
//  stream  | sink   | data_byte: next byte of the class file
//  result  | source | kind, entry_index, tag, word_high, word_low,
//          |        | string_byte, last
//
// One byte is taken every cycle while the command queue has room; the parse
// sequencer settles each byte as it is taken, so that loop sets the rate.
// A result is written into the command queue on its byte's beat, then into the output register.
// Reset (arst_n low) clears the sequencer, the queue and the output valid.
// A stalled result sink fills the two-entry queue; stream.ready then drops
// until the output register drains.
// ----------------------------------------------------------------------------
module class_file_constant_pool_parser_core
	import ccp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	ccp_byte_if.sink      stream,
	ccp_result_if.source  result
);

	// front -> queue
	logic     push;
	ccp_cmd_t push_cmd;
	// queue -> back
	logic     queue_full;
	logic     queue_empty;
	ccp_cmd_t head;
	logic     pop;

	// Classify each byte and sequence the header and pool entries
	ccp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Hold results while the sink stalls
	ccp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head)
	);

	// Format the result words and drive the output register
	ccp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (queue_empty),
		.pop    (pop),
		.result (result)
	);

	// Never push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !queue_full)
		else $error("command pushed into a full queue");

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !queue_empty)
		else $error("command popped from an empty queue");

	// last marks only string bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.last) |-> (result.kind == KIND_STRING))
		else $error("last set on a non-string result");

	// A popped command appears on the result port at the next edge
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> result.valid)
		else $error("popped command did not reach the output register");

endmodule
`default_nettype wire

FILE: tb/ccp_parse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_parse_checker - result predictor and scoreboard for the pool parser
// Follows every accepted byte beat through a parse model of its own and
// compares every accepted result beat, field by field, with the oldest
// expected result.
// ----------------------------------------------------------------------------
module ccp_parse_checker
	import ccp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	ccp_byte_if   byte_mon,
	ccp_result_if res_mon,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] index;
		logic [7:0]  tag;
		logic [31:0] word_high;
		logic [31:0] word_low;
		logic [7:0]  sbyte;
		logic        last;
	} pool_result_t;

	pool_result_t expected_q[$];

	// parse state
	ccp_phase_t  ph;
	logic [3:0]  nbytes;
	logic [63:0] shreg;
	logic [31:0] magic;
	logic [31:0] versions;
	logic [15:0] slot_cnt;
	logic [7:0]  cur_tag;
	logic [15:0] slot;
	logic [15:0] str_left;

	function automatic logic [3:0] operand_len(input logic [7:0] t);
		case (t)
			TAG_CLASS, TAG_STRING:                  return 4'd2;
			TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF,
			TAG_METHODREF, TAG_IMETHODREF,
			TAG_NAMEANDTYPE:                        return 4'd4;
			TAG_LONG, TAG_DOUBLE:                   return 4'd8;
			default:                                return 4'd0;
		endcase
	endfunction

	function automatic pool_result_t make_result(input logic [1:0] k,
			input logic [15:0] idx, input logic [7:0] t, input logic [31:0] hi,
			input logic [31:0] lo, input logic [7:0] sb, input logic lst);
		pool_result_t r;
		r.kind      = k;
		r.index     = idx;
		r.tag       = t;
		r.word_high = hi;
		r.word_low  = lo;
		r.sbyte     = sb;
		r.last      = lst;
		return r;
	endfunction

	// move past the finished entry; idle once the pool is used up
	function automatic void close_slot(input logic [16:0] k);
		logic [16:0] nxt;
		nxt      = {1'b0, slot} + k;
		ph       = (nxt >= {1'b0, slot_cnt}) ? PH_IDLE : PH_TAG;
		slot     = nxt[15:0];
		nbytes   = '0;
		shreg    = '0;
	endfunction

	// returns 1 when the byte completes a result
	function automatic bit parse_byte(input logic [7:0] b, output pool_result_t r);
		logic [3:0]  n;
		logic [31:0] hi;
		logic [31:0] lo;
		r = '0;
		case (ph)
			PH_HEADER: begin
				shreg  = {shreg[55:0], b};
				nbytes = nbytes + 4'd1;
				if (nbytes == HDR_MAGIC_END)
					magic = shreg[31:0];
				if (nbytes == HDR_VER_END)
					versions = shreg[31:0];
				if (nbytes == HDR_LEN) begin
					slot_cnt = shreg[15:0];
					r        = make_result(KIND_HEADER, slot_cnt, 8'd0, magic, versions,
						8'd0, 1'b0);
					slot     = 16'd1;
					nbytes   = '0;
					shreg    = '0;
					ph       = (slot_cnt > 16'd1) ? PH_TAG : PH_IDLE;
					return 1'b1;
				end
				return 1'b0;
			end
			PH_TAG: begin
				cur_tag = b;
				nbytes  = '0;
				shreg   = '0;
				if (b == TAG_UTF8) begin
					ph = PH_ULEN;
					return 1'b0;
				end
				if (operand_len(b) == 4'd0) begin
					r = make_result(KIND_ENTRY, slot, b, 32'd0, 32'd0, 8'd0, 1'b0);
					close_slot(17'd1);
					return 1'b1;
				end
				ph = PH_OPERAND;
				return 1'b0;
			end
			PH_OPERAND: begin
				shreg  = {shreg[55:0], b};
				nbytes = nbytes + 4'd1;
				n      = operand_len(cur_tag);
				if (nbytes < n)
					return 1'b0;
				if (n == 4'd2) begin
					hi = {16'd0, shreg[15:0]};
					lo = '0;
				end else if (n == 4'd8) begin
					hi = shreg[63:32];
					lo = shreg[31:0];
				end else if (cur_tag == TAG_INTEGER || cur_tag == TAG_FLOAT) begin
					hi = shreg[31:0];
					lo = '0;
				end else begin
					hi = {16'd0, shreg[31:16]};
					lo = {16'd0, shreg[15:0]};
				end
				r = make_result(KIND_ENTRY, slot, cur_tag, hi, lo, 8'd0, 1'b0);
				close_slot((cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
				return 1'b1;
			end
			PH_ULEN: begin
				shreg  = {shreg[55:0], b};
				nbytes = nbytes + 4'd1;
				if (nbytes < ULEN_BYTES)
					return 1'b0;
				str_left = shreg[15:0];
				r = make_result(KIND_ENTRY, slot, cur_tag, {16'd0, str_left}, 32'd0,
					8'd0, 1'b0);
				if (str_left == 16'd0) begin
					close_slot(17'd1);
				end else begin
					ph     = PH_UBYTES;
					nbytes = '0;
					shreg  = '0;
				end
				return 1'b1;
			end
			PH_UBYTES: begin
				str_left = str_left - 16'd1;
				r = make_result(KIND_STRING, slot, cur_tag, 32'd0, 32'd0, b,
					str_left == 16'd0);
				if (str_left == 16'd0)
					close_slot(17'd1);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit field_ok(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : score
		pool_result_t r;
		pool_result_t want;
		bit ok;
		if (!arst_n) begin
			ph       = PH_HEADER;
			nbytes   = '0;
			shreg    = '0;
			magic    = '0;
			versions = '0;
			slot_cnt = '0;
			cur_tag  = '0;
			slot     = 16'd1;
			str_left = '0;
			expected_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// predict first: a byte can never produce its result on its own beat
			if (byte_mon.valid && byte_mon.ready)
				if (parse_byte(byte_mon.data_byte, r))
					expected_q.push_back(r);
			if (res_mon.valid && res_mon.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with none expected, kind %0d index %0d tag %0d",
						$time, res_mon.kind, res_mon.entry_index, res_mon.tag);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					ok = field_ok("kind", 32'(want.kind), 32'(res_mon.kind))
						& field_ok("entry_index", 32'(want.index), 32'(res_mon.entry_index))
						& field_ok("tag", 32'(want.tag), 32'(res_mon.tag))
						& field_ok("word_high", want.word_high, res_mon.word_high)
						& field_ok("word_low", want.word_low, res_mon.word_low)
						& field_ok("string_byte", 32'(want.sbyte), 32'(res_mon.string_byte))
						& field_ok("last", 32'(want.last), 32'(res_mon.last));
					if (!ok)
						fail_count <= fail_count + 1;
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

FILE: tb/tb_class_file_constant_pool_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_class_file_constant_pool_parser_core - pool parser testbench
// Streams one class file through the parser: a header, a directed run over
// every tag, mostly with extreme operands, then a long run of random entries up to
// the end of the pool and a tail of bytes the idle parser must drop. Both
// channels idle at random; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_class_file_constant_pool_parser_core;
	import ccp_pkg::*;

	// how operand and string bytes are filled
	typedef enum {
		FILL_RANDOM,
		FILL_ZEROS,
		FILL_ONES
	} fill_t;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   calm;         // high: neither side idles
	int   slot_no;      // next pool slot the stream will describe
	int   pool_slots;   // pool count written into the header
	int   ready_hold;
	int   entry_no;

	ccp_byte_if   byte_ch ();
	ccp_result_if res_ch ();

	class_file_constant_pool_parser_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.result (res_ch)
	);

	ccp_parse_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_ch),
		.res_mon    (res_ch),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result sink: hold ready at a random level for a random stretch,
	// and keep it high throughout a calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			ready_hold   <= 0;
		end else if (calm) begin
			res_ch.ready <= 1'b1;
			ready_hold   <= 0;
		end else if (ready_hold == 0) begin
			res_ch.ready <= ($urandom_range(0, 99) < 65);
			ready_hold   <= pick_idle();
		end else begin
			ready_hold <= ready_hold - 1;
		end
	end

	// Offer one byte, after an optional gap, and hold it until its beat.
	// Returns just after the accepting edge.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	function automatic logic [7:0] fill_byte(input fill_t fill);
		case (fill)
			FILL_ZEROS: return 8'h00;
			FILL_ONES:  return 8'hFF;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one whole pool entry: tag, then its operands or its string.
	// Unknown tags carry nothing after the tag byte.
	task automatic send_entry(input logic [7:0] t, input int str_len, input fill_t fill);
		int n;
		send_byte(t);
		case (t)
			TAG_UTF8:                              n = 0;
			TAG_CLASS, TAG_STRING:                 n = 2;
			TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF,
			TAG_METHODREF, TAG_IMETHODREF,
			TAG_NAMEANDTYPE:                       n = 4;
			TAG_LONG, TAG_DOUBLE:                  n = 8;
			default:                               n = 0;
		endcase
		if (t == TAG_UTF8) begin
			send_byte(str_len[15:8]);
			send_byte(str_len[7:0]);
			repeat (str_len) send_byte(fill_byte(fill));
		end
		repeat (n) send_byte(fill_byte(fill));
		// wide constants use up two slots
		slot_no += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
		entry_no++;
	endtask

	// Mostly standard tags; otherwise one outside the set (zero, two, or
	// anything above the highest standard tag).
	function automatic logic [7:0] random_tag();
		logic [7:0] std_tags [11];
		int r;
		std_tags = '{TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS,
			TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMEANDTYPE};
		// near the end, favour a wide constant so that it runs past the pool
		if (slot_no == pool_slots - 1 && $urandom_range(0, 1) == 1)
			return $urandom_range(0, 1) ? TAG_LONG : TAG_DOUBLE;
		if ($urandom_range(0, 99) < 85)
			return std_tags[$urandom_range(0, 10)];
		r = $urandom_range(0, 2);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd2;
		return 8'($urandom_range(TAG_NAMEANDTYPE + 1, 255));
	endfunction

	function automatic int random_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 6);
		if (r < 97)
			return $urandom_range(7, 24);
		return $urandom_range(25, 60);
	endfunction

	function automatic fill_t random_fill();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return FILL_ZEROS;
		if (r == 1)
			return FILL_ONES;
		return FILL_RANDOM;
	endfunction

	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = 8'h00;
		calm              = 1'b0;
		slot_no           = 1;
		entry_no          = 0;
		pool_slots        = $urandom_range(150, 165);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Header: magic, minor all ones, major all zeros, then the pool count.
		send_byte(8'hCA);
		send_byte(8'hFE);
		send_byte(8'hBA);
		send_byte(8'hBE);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(pool_slots[15:8]);
		send_byte(pool_slots[7:0]);

		// Every tag, most of them with operands at one extreme or the other.
		send_entry(TAG_INTEGER, 0, FILL_ONES);
		send_entry(TAG_FLOAT, 0, FILL_ZEROS);
		send_entry(TAG_LONG, 0, FILL_ONES);
		send_entry(TAG_DOUBLE, 0, FILL_ZEROS);
		send_entry(TAG_CLASS, 0, FILL_ONES);
		send_entry(TAG_STRING, 0, FILL_ZEROS);
		send_entry(TAG_FIELDREF, 0, FILL_RANDOM);
		send_entry(TAG_METHODREF, 0, FILL_RANDOM);
		send_entry(TAG_IMETHODREF, 0, FILL_ONES);
		send_entry(TAG_NAMEANDTYPE, 0, FILL_ZEROS);
		// empty string: length result only
		send_entry(TAG_UTF8, 0, FILL_RANDOM);
		// one-byte string, first byte is also last
		send_entry(TAG_UTF8, 1, FILL_ONES);
		send_entry(TAG_UTF8, 3, FILL_RANDOM);
		// tags outside the standard set, lowest and highest among them
		send_entry(8'd0, 0, FILL_RANDOM);
		send_entry(8'd2, 0, FILL_RANDOM);
		send_entry(TAG_NAMEANDTYPE + 8'd1, 0, FILL_RANDOM);
		send_entry(8'd255, 0, FILL_RANDOM);

		// Hold the stream until the parser has drained every result.
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);

		// Random entries up to the end of the pool, with a calm stretch
		// of back-to-back beats every so often.
		while (slot_no < pool_slots) begin
			calm = (entry_no % 60) >= 48;
			send_entry(random_tag(), random_len(), random_fill());
		end
		calm = 1'b0;

		// The pool is used up: these bytes must be dropped without a result.
		repeat (16) send_byte(8'($urandom_range(0, 255)));
		byte_ch.valid <= 1'b0;

		// Drain, then leave room for any stray result to show.
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
